// ===== hdl/sorted_min_priority_queue_core_assert.svh =====
// Assertion macros for the sorted min-priority queue.
// Included by the modules that check their own logic; needs nothing else.
`ifndef SORTED_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SMPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SMPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/smpq_pkg.sv =====
// Shared types and constants for the sorted min-priority queue.
// Used by smpq_cell and sorted_min_priority_queue_core; depends on nothing.
package smpq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int COUNT_OUT_W   = 5;

    // Operation codes of an input item.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic                      load;
        logic                      op_remove;
        logic signed [VALUE_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ===== hdl/smpq_cell.sv =====
// One cell of the sorted chain: holds one entry and decides its next value.
// Depends on smpq_pkg.
module smpq_cell (
    input  logic                               aclk,
    input  smpq_pkg::cell_ctrl_t               ctrl,
    input  logic                               occupied,
    input  logic signed [smpq_pkg::VALUE_W-1:0] left_value,
    input  logic                               left_gt,
    input  logic signed [smpq_pkg::VALUE_W-1:0] right_value,
    output logic signed [smpq_pkg::VALUE_W-1:0] value,
    output logic signed [smpq_pkg::VALUE_W-1:0] value_next,
    output logic                               gt
);

    logic signed [smpq_pkg::VALUE_W-1:0] value_reg;

    // An empty cell counts as larger than any value, so it takes a shifted entry.
    assign gt    = !occupied || (value_reg > ctrl.value);
    assign value = value_reg;

    // Remove shifts towards the front; insert shifts away from the insert point.
    always_comb begin
        value_next = value_reg;
        if (ctrl.op_remove) begin
            value_next = right_value;
        end else if (gt) begin
            value_next = left_gt ? left_value : ctrl.value;
        end
    end

    // Entry storage; no reset, as only occupied cells are ever read.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            value_reg <= value_next;
        end
    end

endmodule

// ===== hdl/sorted_min_priority_queue_core.sv =====
// Sorted min-priority queue built as a chain of compare-and-shift cells.
// An item's result is registered and presented in the cycle after it is accepted.
// One item per cycle while results are taken: every cell compares against the
// broadcast value and updates at once; the result register frees as it is taken.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
module sorted_min_priority_queue_core #(
    parameter int DEPTH = smpq_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic signed [smpq_pkg::VALUE_W-1:0] s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic signed [smpq_pkg::VALUE_W-1:0] m_front_value,
    output logic                                m_front_valid,
    output logic [smpq_pkg::COUNT_OUT_W-1:0]    m_count
);

`include "sorted_min_priority_queue_core_assert.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]                    count_reg, count_next;
    logic                                m_valid_reg;
    smpq_pkg::status_t                   status_reg, status_next;
    logic signed [smpq_pkg::VALUE_W-1:0] front_reg, front_next;
    logic                                front_valid_reg;
    logic [smpq_pkg::COUNT_OUT_W-1:0]    m_count_reg;

    logic                                s_fire;
    logic                                update;
    logic                                full, empty;
    smpq_pkg::cell_ctrl_t                ctrl;

    logic signed [smpq_pkg::VALUE_W-1:0] cell_value [DEPTH];
    logic signed [smpq_pkg::VALUE_W-1:0] cell_next  [DEPTH];
    logic signed [smpq_pkg::VALUE_W-1:0] left_v     [DEPTH];
    logic signed [smpq_pkg::VALUE_W-1:0] right_v    [DEPTH];
    logic                                cell_gt    [DEPTH];
    logic                                left_g     [DEPTH];

    // A new item is taken whenever the result register is empty or being drained,
    // and never while reset is held.
    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    // Decide status, new count and whether the cells move.
    always_comb begin
        status_next = smpq_pkg::ST_DONE;
        count_next  = count_reg;
        update      = 1'b0;
        unique case (s_operation)
            smpq_pkg::OP_INSERT: begin
                if (full) begin
                    status_next = smpq_pkg::ST_OVERFLOW;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    update     = 1'b1;
                end
            end
            smpq_pkg::OP_REMOVE: begin
                if (empty) begin
                    status_next = smpq_pkg::ST_UNDERFLOW;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    update     = 1'b1;
                end
            end
            default: begin
                status_next = smpq_pkg::ST_DONE;
            end
        endcase
    end

    // Control broadcast to every cell.
    assign ctrl = '{
        load:      s_fire && update,
        op_remove: (s_operation == smpq_pkg::OP_REMOVE),
        value:     s_value
    };

    // The chain of cells, each wired to its two neighbours.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign left_v[i] = '0;
            assign left_g[i] = 1'b0;
        end else begin : g_inner
            assign left_v[i] = cell_value[i-1];
            assign left_g[i] = cell_gt[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_v[i] = cell_value[i];
        end else begin : g_body
            assign right_v[i] = cell_value[i+1];
        end

        smpq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (count_reg > CNT_W'(i)),
            .left_value  (left_v[i]),
            .left_gt     (left_g[i]),
            .right_value (right_v[i]),
            .value       (cell_value[i]),
            .value_next  (cell_next[i]),
            .gt          (cell_gt[i])
        );
    end

    // Front of the queue after this item.
    always_comb begin
        front_next = '0;
        if (count_next != '0) begin
            front_next = update ? cell_next[0] : cell_value[0];
        end
    end

    // Control state: entry count and the result handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg      <= status_next;
            front_reg       <= front_next;
            front_valid_reg <= (count_next != '0);
            m_count_reg     <= smpq_pkg::COUNT_OUT_W'(count_next);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_front_value = front_reg;
    assign m_front_valid = front_valid_reg;
    assign m_count       = m_count_reg;

    // Checks on the queue's own bookkeeping.
    `SMPQ_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH), "count above depth")
    `SMPQ_ASSERT_NEXT(a_insert_grows, aclk, aresetn, s_fire && s_operation == smpq_pkg::OP_INSERT && !full, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow count")
    `SMPQ_ASSERT_NEXT(a_front_flag, aclk, aresetn, s_fire, front_valid_reg == (count_reg != '0), "front flag disagrees with count")
    `SMPQ_ASSERT_NOW(a_front_sorted, aclk, aresetn, count_reg >= CNT_W'(2), cell_value[0] <= cell_value[1], "front entries out of order")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for sorted_min_priority_queue_core: directed table, then random items.
// Every result is checked against a behavioural sorted-array model held in this file.
// Depends on smpq_pkg and the core RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_PERIOD   = 12;
    localparam int  RESET_CYCLES = 6;
    localparam int  QUEUE_DEPTH  = smpq_pkg::DEPTH_DEFAULT;
    localparam int  RANDOM_ITEMS = 500;
    localparam int  BURST_ITEMS  = 40;
    localparam int  HOLD_CYCLES  = 200;
    localparam int  TAIL_CYCLES  = 8;
    localparam int  REPORT_LIMIT = 10;
    localparam time RUN_LIMIT    = 5_000_000;

    // One result item as the block presents it.
    typedef struct packed {
        smpq_pkg::status_t                   status;
        logic signed [smpq_pkg::VALUE_W-1:0] front_value;
        logic                                front_valid;
        logic [smpq_pkg::COUNT_OUT_W-1:0]    count;
    } queue_result_t;

    // One row of the directed table; the result is only used where typed is set.
    typedef struct {
        logic                                op;
        logic signed [smpq_pkg::VALUE_W-1:0] value;
        bit                                  typed;
        queue_result_t                       result;
    } directed_row_t;

    localparam queue_result_t NO_RESULT = '{smpq_pkg::ST_DONE, 32'sd0, 1'b0, 5'd0};

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic                                s_operation;
    logic signed [smpq_pkg::VALUE_W-1:0] s_value;
    logic                                m_valid;
    logic                                m_ready;
    logic [1:0]                          m_status;
    logic signed [smpq_pkg::VALUE_W-1:0] m_front_value;
    logic                                m_front_valid;
    logic [smpq_pkg::COUNT_OUT_W-1:0]    m_count;

    // Model state: ascending entries and the number held.
    logic signed [smpq_pkg::VALUE_W-1:0] model_vals [QUEUE_DEPTH] = '{default: '0};
    int                                  model_len = 0;

    queue_result_t pending_results[$];
    queue_result_t typed_results[int];

    int  items_sent   = 0;
    int  results_seen = 0;
    int  mismatches   = 0;
    int  n_inserts    = 0;
    int  n_removes    = 0;
    int  n_overflows  = 0;
    int  n_underflows = 0;
    int  tx_idle_pct  = 0;
    int  rx_idle_pct  = 0;
    int  insert_bias  = 50;
    logic hold_req;
    logic hold_ack;

    directed_row_t directed_rows [25] = '{
        '{smpq_pkg::OP_REMOVE, 32'shFFFFFFFF, 1'b1,
          '{smpq_pkg::ST_UNDERFLOW, 32'sd0, 1'b0, 5'd0}},
        '{smpq_pkg::OP_INSERT, 32'sh00000000, 1'b1,
          '{smpq_pkg::ST_DONE, 32'sd0, 1'b1, 5'd1}},
        '{smpq_pkg::OP_INSERT, 32'sh7FFFFFFF, 1'b1,
          '{smpq_pkg::ST_DONE, 32'sd0, 1'b1, 5'd2}},
        '{smpq_pkg::OP_INSERT, 32'sh80000000, 1'b1,
          '{smpq_pkg::ST_DONE, 32'sh80000000, 1'b1, 5'd3}},
        '{smpq_pkg::OP_INSERT, 32'shFFFFFFFF, 1'b1,
          '{smpq_pkg::ST_DONE, 32'sh80000000, 1'b1, 5'd4}},
        '{smpq_pkg::OP_INSERT, 32'shFFFFFFFF, 1'b0, NO_RESULT},
        '{smpq_pkg::OP_INSERT, 32'sd5,        1'b0, NO_RESULT},
        '{smpq_pkg::OP_INSERT, -32'sd5,       1'b0, NO_RESULT},
        '{smpq_pkg::OP_INSERT, 32'sh55555555, 1'b0, NO_RESULT},
        '{smpq_pkg::OP_INSERT, 32'shAAAAAAAA, 1'b0, NO_RESULT},
        '{smpq_pkg::OP_INSERT, 32'sd1,        1'b0, NO_RESULT},
        '{smpq_pkg::OP_INSERT, -32'sd2,       1'b0, NO_RESULT},
        '{smpq_pkg::OP_INSERT, 32'sd100,      1'b0, NO_RESULT},
        '{smpq_pkg::OP_INSERT, -32'sd100,     1'b0, NO_RESULT},
        '{smpq_pkg::OP_INSERT, 32'sh7FFFFFFE, 1'b0, NO_RESULT},
        '{smpq_pkg::OP_INSERT, 32'sh80000001, 1'b0, NO_RESULT},
        '{smpq_pkg::OP_INSERT, 32'sh00000000, 1'b0, NO_RESULT},
        '{smpq_pkg::OP_INSERT, 32'sd42,       1'b1,
          '{smpq_pkg::ST_OVERFLOW, 32'sh80000000, 1'b1, 5'd16}},
        '{smpq_pkg::OP_INSERT, 32'sh80000000, 1'b1,
          '{smpq_pkg::ST_OVERFLOW, 32'sh80000000, 1'b1, 5'd16}},
        '{smpq_pkg::OP_REMOVE, 32'sh00000000, 1'b0, NO_RESULT},
        '{smpq_pkg::OP_REMOVE, 32'sh7FFFFFFF, 1'b0, NO_RESULT},
        '{smpq_pkg::OP_REMOVE, 32'sh80000000, 1'b0, NO_RESULT},
        '{smpq_pkg::OP_REMOVE, 32'sh55555555, 1'b0, NO_RESULT},
        '{smpq_pkg::OP_REMOVE, 32'shAAAAAAAA, 1'b0, NO_RESULT},
        '{smpq_pkg::OP_REMOVE, 32'sh12345678, 1'b0, NO_RESULT}
    };

    sorted_min_priority_queue_core #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_front_value (m_front_value),
        .m_front_valid (m_front_valid),
        .m_count       (m_count)
    );

    // Free-running clock.
    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Apply one operation to the model queue and return the result it should give.
    function automatic queue_result_t sorted_queue_apply(logic op,
                                                         logic signed [smpq_pkg::VALUE_W-1:0] v);
        queue_result_t r;
        int            pos;
        r.status = smpq_pkg::ST_DONE;
        if (op == smpq_pkg::OP_INSERT) begin
            if (model_len >= QUEUE_DEPTH) begin
                r.status = smpq_pkg::ST_OVERFLOW;
            end else begin
                // Equal entries stay ahead of the new one.
                pos = 0;
                while (pos < model_len && model_vals[pos] <= v) pos++;
                for (int k = model_len; k > pos; k--) model_vals[k] = model_vals[k-1];
                model_vals[pos] = v;
                model_len++;
            end
        end else if (model_len == 0) begin
            r.status = smpq_pkg::ST_UNDERFLOW;
        end else begin
            for (int k = 0; k + 1 < model_len; k++) model_vals[k] = model_vals[k+1];
            model_len--;
        end
        r.front_valid = (model_len != 0);
        r.front_value = r.front_valid ? model_vals[0] : '0;
        r.count       = smpq_pkg::COUNT_OUT_W'(model_len);
        return r;
    endfunction

    function automatic void flag_failure(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function automatic void check_result(queue_result_t want, queue_result_t seen, string source);
        if (seen.status !== want.status || seen.front_value !== want.front_value ||
            seen.front_valid !== want.front_valid || seen.count !== want.count) begin
            flag_failure($sformatf(
                {"Result %0d (%s): expected status %0d front %0d valid %0b count %0d, ",
                 "got status %0d front %0d valid %0b count %0d"},
                results_seen, source, want.status, want.front_value, want.front_valid,
                want.count, seen.status, seen.front_value, seen.front_valid, seen.count));
        end
    endfunction

    // Predict on every accepted item and check every accepted result.
    always @(posedge aclk) begin : result_monitor
        queue_result_t want;
        queue_result_t seen;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = sorted_queue_apply(s_operation, s_value);
                pending_results.push_back(want);
                if (s_operation == smpq_pkg::OP_INSERT) n_inserts++;
                else n_removes++;
                if (want.status == smpq_pkg::ST_OVERFLOW) n_overflows++;
                if (want.status == smpq_pkg::ST_UNDERFLOW) n_underflows++;
            end
            if (m_valid && m_ready) begin
                seen = '{smpq_pkg::status_t'(m_status), m_front_value, m_front_valid, m_count};
                if (pending_results.size() == 0) begin
                    flag_failure($sformatf("Result %0d arrived with no item outstanding",
                                           results_seen));
                end else begin
                    want = pending_results.pop_front();
                    check_result(want, seen, "model");
                    if (typed_results.exists(results_seen))
                        check_result(typed_results[results_seen], seen, "table");
                end
                results_seen++;
            end
        end
    end

    // Result side: random back-pressure, or a long hold when the stimulus asks for one.
    initial begin : result_sink
        m_ready  = 1'b0;
        hold_ack = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_ack) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_ack <= hold_req;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Offer one item, with an optional random gap first, and return at the edge it is taken.
    task automatic send_item(input logic op, input logic signed [smpq_pkg::VALUE_W-1:0] v);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= v;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Mostly full-range values, with small clustered ones for duplicates and the extremes.
    function automatic logic signed [smpq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return int'($urandom_range(0, 16)) - 8;
            7:          return $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 3)
                                                    : 32'sh80000000 + $urandom_range(0, 3);
            default:    return $urandom_range(0, 255) << 24;
        endcase
    endfunction

    // Random items in runs that lean towards filling, draining or neither.
    task automatic run_random(input int n);
        logic op;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_bias = 80;
                    1:       insert_bias = 50;
                    default: insert_bias = 20;
                endcase
            end
            op = ($urandom_range(0, 99) < insert_bias) ? smpq_pkg::OP_INSERT
                                                       : smpq_pkg::OP_REMOVE;
            send_item(op, pick_value());
        end
    endtask

    // Hold the result side for a long stretch while inserts keep coming.
    task automatic stall_receiver_burst();
        int saved_pct;
        saved_pct = tx_idle_pct;
        wait_for_results();
        hold_req    <= ~hold_req;
        tx_idle_pct = 0;
        repeat (BURST_ITEMS) send_item(smpq_pkg::OP_INSERT, pick_value());
        tx_idle_pct = saved_pct;
        s_valid <= 1'b0;
        while (hold_ack != hold_req) @(posedge aclk);
    endtask

    // Main stimulus sequence.
    initial begin : stimulus
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = smpq_pkg::OP_INSERT;
        s_value     = '0;
        hold_req    = 1'b0;
        tx_idle_pct = 28;
        rx_idle_pct = 77;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows: extremes, duplicates, full and empty queue.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].typed) typed_results[items_sent] = directed_rows[i].result;
            send_item(directed_rows[i].op, directed_rows[i].value);
        end
        run_random(RANDOM_ITEMS);
        stall_receiver_burst();

        // Sender slow, receiver eager.
        tx_idle_pct = 77;
        rx_idle_pct = 28;
        run_random(RANDOM_ITEMS);
        wait_for_results();

        // No idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(RANDOM_ITEMS);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            flag_failure($sformatf("%0d results never arrived", pending_results.size()));

        $display("Covered %0d items (%0d inserts, %0d removes) giving %0d overflow and %0d %s",
                 items_sent, n_inserts, n_removes, n_overflows, n_underflows,
                 "underflow results,");
        $display("under three idling mixes and a %0d-cycle output stall; %0d mismatches.",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0) begin
            $display("sorted_min_priority_queue_core regression: pass");
        end else begin
            $display("sorted_min_priority_queue_core regression: fail");
        end
        $finish;
    end

    // Watchdog in case the block hangs.
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("Run timed out with %0d results outstanding.", pending_results.size());
        $display("sorted_min_priority_queue_core regression: fail");
        $finish;
    end

endmodule

// ===== sorted_min_priority_queue_core.f =====
+incdir+hdl
hdl/smpq_pkg.sv
hdl/smpq_cell.sv
hdl/sorted_min_priority_queue_core.sv
tb/testbench.sv
